FILE: hw/rtl/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg: shared types and constants for the pixel blend unit
// Blend mode codes, lane control word, register indexes and the /255 helper.
// ----------------------------------------------------------------------------
package pbm_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned NUM_LANES  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CH_W-1:0] CH_MAX   = 8'hFF;
  localparam logic [CH_W-1:0] TOP_NONE = 8'h00;
  localparam logic [CH_W-1:0] TOP_FULL = 8'hFF;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALPHA = 2'd1;

  typedef enum logic [1:0] {
    MODE_OVER   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_MUL    = 2'd2,
    MODE_SCREEN = 2'd3
  } pbm_mode_t;

  // configuration seen by every lane
  typedef struct packed {
    pbm_mode_t       mode;
    logic [CH_W-1:0] alpha;
  } pbm_ctl_t;

  // x / 255 by reciprocal: (x + 1 + (x >> 8)) >> 8, exact for x <= 65534.
  // All callers stay at or below 255 * 255.
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

FILE: hw/rtl/pbm_lane.sv
// ----------------------------------------------------------------------------
// pbm_lane: one color channel of the blend datapath
// Three-step channel mix: products, /255 plus second product, final /255.
// ----------------------------------------------------------------------------
module pbm_lane import pbm_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  pbm_ctl_t        ctl,
  input  logic [CH_W-1:0] s,
  input  logic [CH_W-1:0] d,
  output logic [CH_W-1:0] v
);

  logic [CH_W-1:0] s_e, d_e, b_op;
  logic [15:0]     p0_nxt, p1_nxt;
  logic [15:0]     p0_r, p1_r;
  logic [CH_W-1:0] d1_r;

  logic [16:0]     sum;
  logic [CH_W-1:0] q0, q1;
  logic [CH_W:0]   add_t;
  logic [CH_W-1:0] pre_nxt;
  logic [15:0]     m_nxt;
  logic [15:0]     m_r;
  logic [CH_W-1:0] q1_r, pre_r;

  logic [CH_W:0]   mm;

  // stage 1: screen works on inverted channels; pick second operand by mode
  always_comb begin
    s_e = (ctl.mode == MODE_SCREEN) ? ~s : s;
    d_e = (ctl.mode == MODE_SCREEN) ? ~d : d;
    case (ctl.mode)
      MODE_OVER, MODE_ADD: b_op = ctl.alpha;
      MODE_MUL, MODE_SCREEN: b_op = d_e;
      default: b_op = ctl.alpha;
    endcase
    p0_nxt = 16'(s_e) * 16'(b_op);
    p1_nxt = 16'(d_e) * 16'(CH_MAX - ctl.alpha);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      d1_r <= d_e;
    end
  end

  // stage 2: over and additive finish here; multiply and screen form q(s*d)*a
  always_comb begin
    sum   = {1'b0, p0_r} + {1'b0, p1_r};
    q0    = div255(p0_r);
    q1    = div255(p1_r);
    add_t = {1'b0, q0} + {1'b0, d1_r};
    case (ctl.mode)
      MODE_OVER: pre_nxt = div255(sum[15:0]);
      MODE_ADD:  pre_nxt = add_t[CH_W] ? CH_MAX : add_t[CH_W-1:0];
      default:   pre_nxt = '0;
    endcase
    m_nxt = 16'(q0) * 16'(ctl.alpha);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r   <= m_nxt;
      q1_r  <= q1;
      pre_r <= pre_nxt;
    end
  end

  // stage 3: multiply/screen sum never exceeds the (screen-inverted) destination
  always_comb begin
    mm = {1'b0, div255(m_r)} + {1'b0, q1_r};
    case (ctl.mode)
      MODE_MUL:    v = mm[CH_W-1:0];
      MODE_SCREEN: v = ~mm[CH_W-1:0];
      default:     v = pre_r;
    endcase
  end

endmodule

FILE: hw/rtl/pbm_merge.sv
// ----------------------------------------------------------------------------
// pbm_merge: output stage of the blend unit
// Joins the lane channels, applies pass-through cases and the top byte rule.
// ----------------------------------------------------------------------------
module pbm_merge import pbm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  pbm_ctl_t                  ctl,
  input  logic                      vld,
  input  logic [PIX_W-1:0]          src,
  input  logic [PIX_W-1:0]          dst,
  input  logic [NUM_LANES*CH_W-1:0] lanes,
  output logic                      out_valid,
  output logic [PIX_W-1:0]          out_pixel
);

  logic             out_valid_r;
  logic [PIX_W-1:0] pixel_nxt, pixel_r;

  // pass-through first, then the lane word with its top byte
  always_comb begin
    if (ctl.alpha == '0) begin
      pixel_nxt = dst;
    end else if (ctl.mode == MODE_OVER && ctl.alpha == CH_MAX) begin
      pixel_nxt = src;
    end else if (ctl.mode == MODE_SCREEN) begin
      pixel_nxt = {TOP_FULL, lanes};
    end else begin
      pixel_nxt = {TOP_NONE, lanes};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = pixel_r;

endmodule

FILE: hw/rtl/pixel_blend_modes.sv
// ----------------------------------------------------------------------------
// pixel_blend_modes: per-pixel blend of a source over a destination
// Three channel lanes and an output merge stage in a three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall carry one word of source and destination
//   pixel (RGB in bits 23:0). Output channel: out_valid/out_stall carry one
//   blended pixel word. A word moves when valid is high and stall is low.
//   Config: cfg_valid/cfg_ready (ready is always high); index 0 is the blend
//   mode (over, additive, multiply, screen), index 1 the surface alpha.
//   Other indexes are dropped. Write config only while the pipe is empty.
// Throughput: one pixel per cycle unless stalled; pixels are independent.
// Pipeline: an accepted word goes through three registers (lane products,
//   lane second product, output register) before it shows on out_*.
// Stall: while out_valid is high and out_stall is asserted the whole pipe
//   holds and in_stall is raised; the presented word stays unchanged.
// Reset: synchronous, active low; clears valid bits, mode to source over
//   and alpha to 255 (opaque).
// ----------------------------------------------------------------------------
module pixel_blend_modes import pbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_src_pixel,
  input  logic [PIX_W-1:0]      in_dst_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_result_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pbm_mode_t        blend_mode_r;
  logic [CH_W-1:0]  surface_alpha_r;
  pbm_ctl_t         ctl;
  logic             en;
  logic             v1_r, v2_r;
  logic [PIX_W-1:0] src1_r, dst1_r, src2_r, dst2_r;
  logic [NUM_LANES*CH_W-1:0] lanes;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r    <= MODE_OVER;
      surface_alpha_r <= CH_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_MODE:  blend_mode_r    <= pbm_mode_t'(cfg_data[1:0]);
        CFG_IDX_ALPHA: surface_alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ctl.mode  = blend_mode_r;
  assign ctl.alpha = surface_alpha_r;

  // pipe advances unless the presented word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // pixel words ride along for the pass-through cases
  always_ff @(posedge clk) begin
    if (en) begin
      src1_r <= in_src_pixel;
      dst1_r <= in_dst_pixel;
      src2_r <= src1_r;
      dst2_r <= dst1_r;
    end
  end

  // one lane per color channel
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    pbm_lane u_lane (
      .clk (clk),
      .en  (en),
      .ctl (ctl),
      .s   (in_src_pixel[k*CH_W +: CH_W]),
      .d   (in_dst_pixel[k*CH_W +: CH_W]),
      .v   (lanes[k*CH_W +: CH_W])
    );
  end

  pbm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (ctl),
    .vld       (v2_r),
    .src       (src2_r),
    .dst       (dst2_r),
    .lanes     (lanes),
    .out_valid (out_valid),
    .out_pixel (out_result_pixel)
  );

  // a word moving down the pipe is never dropped
  a_v1_to_v2: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && en) |=> v2_r) else $error("stage 1 word lost");

  a_v2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en) |=> out_valid) else $error("stage 2 word lost");

  // a held pipe keeps its occupancy
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v1_r) && $stable(v2_r)))
    else $error("pipe moved while held");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pixel_blend_modes
// Drives source/destination pixel words with random gaps, stalls the result
// side at random and checks every blended word against a local predictor.
// Config writes happen only with the pipe drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench import pbm_pkg::*; ();

  localparam int unsigned CH_FULL   = 32'(CH_MAX);
  localparam int unsigned MAX_IDLE  = 6;
  localparam int unsigned PIPE_WAIT = 4;
  localparam int unsigned TIMEOUT   = 200000;

  // indexes with no register behind them; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_src_pixel = '0;
  logic [PIX_W-1:0]      in_dst_pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_result_pixel;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the configuration
  pbm_mode_t       cur_mode = MODE_OVER;
  logic [CH_W-1:0] cur_alpha = CH_MAX;

  logic [PIX_W-1:0] expected_pixels[$];
  int unsigned      err_count = 0;
  int unsigned      cycle_count = 0;
  bit               idle_on = 1'b1;
  int unsigned      long_hold_req = 0;

  pixel_blend_modes dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_src_pixel     (in_src_pixel),
    .in_dst_pixel     (in_dst_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_pixel (out_result_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // multiply lane: product scaled by alpha, plus destination weighted by 1-alpha
  function automatic int unsigned mul_lane(int unsigned s, int unsigned d, int unsigned a);
    return (s * d / CH_FULL) * a / CH_FULL + d * (CH_FULL - a) / CH_FULL;
  endfunction

  function automatic logic [PIX_W-1:0] blend_pixel(pbm_mode_t mode, logic [CH_W-1:0] alpha,
                                                   logic [PIX_W-1:0] src,
                                                   logic [PIX_W-1:0] dst);
    logic [PIX_W-1:0] res;
    int unsigned      a;
    int unsigned      sc;
    int unsigned      dc;
    int unsigned      v;
    a = 32'(alpha);
    // transparent surface leaves the destination untouched
    if (a == 0) return dst;
    // opaque source-over copies the source word whole
    if (mode == MODE_OVER && a == CH_FULL) return src;
    res = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      sc = 32'(src[CH_W*k +: CH_W]);
      dc = 32'(dst[CH_W*k +: CH_W]);
      case (mode)
        MODE_ADD: begin
          v = sc * a / CH_FULL + dc;
          if (v > CH_FULL) v = CH_FULL;
        end
        MODE_MUL:    v = mul_lane(sc, dc, a);
        MODE_SCREEN: v = CH_FULL - mul_lane(CH_FULL - sc, CH_FULL - dc, a);
        default:     v = (sc * a + dc * (CH_FULL - a)) / CH_FULL;
      endcase
      res[CH_W*k +: CH_W] = v[CH_W-1:0];
    end
    res[PIX_W-1 -: CH_W] = (mode == MODE_SCREEN) ? TOP_FULL : TOP_NONE;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
    $display("%0t: mismatch, %s: got %h expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_result(input logic [PIX_W-1:0] got);
    logic [PIX_W-1:0] want;
    if (expected_pixels.size() == 0) begin
      report_mismatch("result word with nothing pending", got, '0);
    end else begin
      want = expected_pixels.pop_front();
      if (got !== want) report_mismatch("result_pixel", got, want);
    end
  endtask

  // result side: check accepted words, then draw the stall before the next one
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) begin
        check_result(out_result_pixel);
        wait_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      // long hold-off counted here so the pipe fills and stalls its input
      if (long_hold_req > 0) begin
        wait_left = long_hold_req;
        long_hold_req = 0;
      end
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // one word on the input channel; in_valid stays high for back-to-back words
  task automatic send_pixels(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_pixel <= src;
    in_dst_pixel <= dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(blend_pixel(cur_mode, cur_alpha, src, dst));
  endtask

  // stop offering words and let every pending result come out
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IDX_MODE:  cur_mode = pbm_mode_t'(data[1:0]);
      CFG_IDX_ALPHA: cur_alpha = data;
      default: ;
    endcase
  endtask

  // random word, with some channels forced to the rails
  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] p;
    p = $urandom();
    for (int b = 0; b < PIX_W / CH_W; b++)
      if ($urandom_range(0, 4) == 0) p[CH_W*b +: CH_W] = $urandom_range(0, 1) ? CH_MAX : '0;
    return p;
  endfunction

  function automatic logic [CH_W-1:0] random_alpha();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CH_MAX;
      2:       return CH_W'($urandom_range(1, 2));
      3:       return CH_W'($urandom_range(253, 254));
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset leaves opaque source-over: the source word comes back whole
  task automatic test_reset_defaults();
    send_pixels(32'hA5123456, 32'h5A654321);
    send_pixels(32'hFFFFFFFF, 32'h00000000);
    send_pixels(32'h00000000, 32'hFFFFFFFF);
  endtask

  // every mode at alpha 255 and 1 on rail/grey pixels, plus transparent screen
  task automatic test_mode_extremes();
    pbm_mode_t modes[4];
    modes = '{MODE_OVER, MODE_ADD, MODE_MUL, MODE_SCREEN};
    foreach (modes[i]) begin
      write_reg(CFG_IDX_MODE, {{(CFG_DATA_W-2){1'b0}}, modes[i]});
      write_reg(CFG_IDX_ALPHA, CH_MAX);
      send_pixels(32'h00000000, 32'hFFFFFFFF);
      send_pixels(32'hFFFFFFFF, 32'h80808080);
      write_reg(CFG_IDX_ALPHA, 8'h01);
      send_pixels(32'h00000000, 32'hFFFFFFFF);
      send_pixels(32'hFFFFFFFF, 32'h80808080);
    end
    write_reg(CFG_IDX_ALPHA, '0);
    send_pixels(32'h12345678, 32'hCAFE0F1E);
    send_pixels(32'hFFFFFFFF, 32'h00000000);
  endtask

  // dropped indexes and mode data with upper bits set
  task automatic test_register_quirks();
    write_reg(CFG_IDX_SPARE_LO, 8'h00);
    write_reg(CFG_IDX_SPARE_HI, 8'hFF);
    write_reg(CFG_IDX_MODE, 8'hFD);
    write_reg(CFG_IDX_ALPHA, 8'h80);
    send_pixels(32'hFF804020, 32'h10204080);
    send_pixels(32'h00FFFFFF, 32'hFFFFFFFF);
  endtask

  // long result hold-off while words keep coming, then a full drain
  task automatic test_backpressure();
    int unsigned n;
    write_reg(CFG_IDX_MODE, {{(CFG_DATA_W-2){1'b0}}, MODE_MUL});
    write_reg(CFG_IDX_ALPHA, 8'hC3);
    idle_on = 1'b0;
    long_hold_req = 60;
    for (n = 0; n < 40; n++) send_pixels(random_pixel(), random_pixel());
    drain_pipe();
    idle_on = 1'b1;
    for (n = 0; n < 20; n++) send_pixels(random_pixel(), random_pixel());
  endtask

  // random configuration per phase, random words within it
  task automatic test_random_blend(input int unsigned phases, input int unsigned per_phase);
    logic [CFG_DATA_W-1:0] mode_word;
    for (int p = 0; p < phases; p++) begin
      mode_word = CFG_DATA_W'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_IDX_MODE, mode_word);
        write_reg(CFG_IDX_ALPHA, random_alpha());
      end else begin
        write_reg(CFG_IDX_ALPHA, random_alpha());
        write_reg(CFG_IDX_MODE, mode_word);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom_range(0, 255)));
      // every fifth phase runs without gaps on either side
      idle_on = (p % 5 != 4);
      for (int n = 0; n < per_phase; n++) send_pixels(random_pixel(), random_pixel());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_mode_extremes();
    test_register_quirks();
    test_backpressure();
    test_random_blend(26, 50);
    drain_pipe();
    repeat (10) @(posedge clk);
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: pixel_blend_modes.f
hw/rtl/pbm_pkg.sv
hw/rtl/pbm_lane.sv
hw/rtl/pbm_merge.sv
hw/rtl/pixel_blend_modes.sv
verif/testbench.sv
